>>> sv/interval_overlap_accounting_defines.svh
// ----------------------------------------------------------------------------
// Interval overlap accounting: assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_OVERLAP_ACCOUNTING_DEFINES_SVH
`define INTERVAL_OVERLAP_ACCOUNTING_DEFINES_SVH

// same-cycle implication
`define IOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ioa_pkg.sv
// ----------------------------------------------------------------------------
// Interval overlap accounting package
// Transaction types, operation codes and default table depths.
// ----------------------------------------------------------------------------
`default_nettype none

package ioa_pkg;

  localparam int CONC_DEPTH_DEF = 16;
  localparam int XFER_DEPTH_DEF = 16;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_OBSERVE = 2'd1;
  localparam logic [1:0] OP_DIRECT  = 2'd2;

  localparam logic HOST_TO_DEVICE = 1'b0;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] start_ns;
    logic [63:0] end_ns;
    logic        to_concurrent;
    logic        to_transfer;
    logic        direction;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [63:0] stall_sum;
    logic [63:0] overlap_sum;
    logic [63:0] h2d_sum;
    logic [63:0] d2h_sum;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/interval_overlap_accounting.sv
// Flow: add or unused code passes EXEC then FIN, direct EXEC, DIRECT, FIN, and
// observe EXEC, WALK, FIN, where WALK reads every interval stored in both
// tables together; FIN waits while the result register is full.
// One transaction in flight; in_ready returns in the same cycle that out_valid rises;
// observe walks the tables one entry per cycle through one read port each.
// Reset clears the fill counts and totals; table contents are not cleared.
// ----------------------------------------------------------------------------
// Interval overlap accounting
// Bounded concurrent and transfer interval tables in memory, walked against
// a compute window to accumulate saturating stall, overlap and per-direction totals.
// ----------------------------------------------------------------------------
`default_nettype none
`include "interval_overlap_accounting_defines.svh"

module interval_overlap_accounting
  import ioa_pkg::*;
#(
  parameter int CONC_DEPTH = CONC_DEPTH_DEF,
  parameter int XFER_DEPTH = XFER_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CUW = $clog2(CONC_DEPTH + 1);
  localparam int CAW = (CONC_DEPTH > 1) ? $clog2(CONC_DEPTH) : 1;
  localparam int XUW = $clog2(XFER_DEPTH + 1);
  localparam int XAW = (XFER_DEPTH > 1) ? $clog2(XFER_DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_DIRECT = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  typedef struct packed {
    logic [63:0] start_ns;
    logic [63:0] end_ns;
  } conc_ent_t;

  typedef struct packed {
    logic        direction;
    logic [63:0] start_ns;
    logic [63:0] end_ns;
  } xfer_ent_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  state_t    state_r, state_nxt;
  in_item_t  req_r;
  out_item_t out_r;
  logic      out_valid_r;
  logic      acc_r;

  logic [CUW-1:0] conc_used_r, cidx_r;
  logic [XUW-1:0] xfer_used_r, xidx_r;
  logic [63:0]    stall_r, overlap_r, h2d_r, d2h_r;
  logic [63:0]    dlen_r;

  conc_ent_t conc_mem [CONC_DEPTH];
  xfer_ent_t xfer_mem [XFER_DEPTH];

  conc_ent_t   crd_r;
  xfer_ent_t   xrd_r;
  logic        v_rd_r, tag_rd_r;
  logic [63:0] lo1_r, hi1_r, len1_r;
  logic        v1_r, tag1_r, dir1_r;
  logic [63:0] ov2_r, len2_r;
  logic        v2_r, tag2_r, dir2_r;
  logic [63:0] term3_r;
  logic        v3_r, tag3_r, dir3_r;

  logic        is_exec, nonempty, c_full, x_full, add_reject;
  logic        conc_we, xfer_we;
  logic        c_issue, x_issue, issue_done, walk_done, out_free;
  logic [63:0] sel_s, sel_e;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign is_exec    = (state_r == ST_EXEC);
  assign nonempty   = req_r.end_ns > req_r.start_ns;
  assign c_full     = (conc_used_r == CUW'(CONC_DEPTH));
  assign x_full     = (xfer_used_r == XUW'(XFER_DEPTH));
  assign add_reject = nonempty && ((req_r.to_concurrent && c_full) ||
                                   (req_r.to_transfer && x_full));
  assign conc_we    = is_exec && (req_r.operation == OP_ADD) && nonempty && !add_reject &&
                      req_r.to_concurrent;
  assign xfer_we    = is_exec && (req_r.operation == OP_ADD) && nonempty && !add_reject &&
                      req_r.to_transfer;

  assign c_issue    = (state_r == ST_WALK) && (cidx_r < conc_used_r);
  assign x_issue    = (state_r == ST_WALK) && !c_issue && (xidx_r < xfer_used_r);
  assign issue_done = (cidx_r == conc_used_r) && (xidx_r == xfer_used_r);
  assign walk_done  = (state_r == ST_WALK) && issue_done &&
                      !(v_rd_r || v1_r || v2_r || v3_r);

  assign sel_s = tag_rd_r ? xrd_r.start_ns : crd_r.start_ns;
  assign sel_e = tag_rd_r ? xrd_r.end_ns : crd_r.end_ns;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (req_r.operation)
          OP_OBSERVE: state_nxt = ST_WALK;
          OP_DIRECT:  state_nxt = ST_DIRECT;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_WALK: begin
        if (walk_done) state_nxt = ST_FIN;
      end
      ST_DIRECT: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      conc_used_r <= '0;
      xfer_used_r <= '0;
      cidx_r      <= '0;
      xidx_r      <= '0;
      stall_r     <= '0;
      overlap_r   <= '0;
      h2d_r       <= '0;
      d2h_r       <= '0;
      v_rd_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (conc_we) conc_used_r <= conc_used_r + CUW'(1);
      if (xfer_we) xfer_used_r <= xfer_used_r + XUW'(1);
      if (is_exec) begin
        cidx_r <= '0;
        xidx_r <= '0;
      end else begin
        if (c_issue) cidx_r <= cidx_r + CUW'(1);
        if (x_issue) xidx_r <= xidx_r + XUW'(1);
      end
      if (walk_done) begin
        conc_used_r <= '0;
        xfer_used_r <= '0;
      end
      v_rd_r <= c_issue || x_issue;
      v1_r   <= v_rd_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      if (state_r == ST_DIRECT) stall_r <= sat_add(stall_r, dlen_r);
      if (v3_r) begin
        if (!tag3_r) begin
          stall_r <= sat_add(stall_r, term3_r);
        end else begin
          overlap_r <= sat_add(overlap_r, term3_r);
          if (dir3_r == HOST_TO_DEVICE) h2d_r <= sat_add(h2d_r, term3_r);
          else d2h_r <= sat_add(d2h_r, term3_r);
        end
      end
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (conc_we) begin
      conc_mem[conc_used_r[CAW-1:0]] <= {req_r.start_ns, req_r.end_ns};
    end
    if (xfer_we) begin
      xfer_mem[xfer_used_r[XAW-1:0]] <= {req_r.direction, req_r.start_ns, req_r.end_ns};
    end
    crd_r <= conc_mem[cidx_r[CAW-1:0]];
    xrd_r <= xfer_mem[xidx_r[XAW-1:0]];
  end

  // transaction capture, walk datapath, result register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    if (is_exec) begin
      acc_r  <= !((req_r.operation == OP_ADD) && add_reject);
      dlen_r <= nonempty ? (req_r.end_ns - req_r.start_ns) : 64'd0;
    end
    tag_rd_r <= x_issue;
    lo1_r    <= (sel_s > req_r.start_ns) ? sel_s : req_r.start_ns;
    hi1_r    <= (sel_e < req_r.end_ns) ? sel_e : req_r.end_ns;
    len1_r   <= (sel_e > sel_s) ? (sel_e - sel_s) : 64'd0;
    tag1_r   <= tag_rd_r;
    dir1_r   <= xrd_r.direction;
    ov2_r    <= (hi1_r > lo1_r) ? (hi1_r - lo1_r) : 64'd0;
    len2_r   <= len1_r;
    tag2_r   <= tag1_r;
    dir2_r   <= dir1_r;
    term3_r  <= tag2_r ? ov2_r : (len2_r - ov2_r);
    tag3_r   <= tag2_r;
    dir3_r   <= dir2_r;
    if (state_r == ST_FIN && out_free) begin
      out_r.accepted    <= acc_r;
      out_r.stall_sum   <= stall_r;
      out_r.overlap_sum <= overlap_r;
      out_r.h2d_sum     <= h2d_r;
      out_r.d2h_sum     <= d2h_r;
    end
  end

  `IOA_ASSERT_NOW(a_conc_bound, 1'b1, conc_used_r <= CUW'(CONC_DEPTH), "conc count overflow")
  `IOA_ASSERT_NOW(a_xfer_bound, 1'b1, xfer_used_r <= XUW'(XFER_DEPTH), "xfer count overflow")
  `IOA_ASSERT_NOW(a_pipe_idle, state_r != ST_WALK, !(v_rd_r || v1_r || v2_r || v3_r), "pipe busy")
  `IOA_ASSERT_NEXT(a_walk_clear, walk_done, (conc_used_r == '0) && (xfer_used_r == '0), "tables not emptied")
  `IOA_ASSERT_NEXT(a_fin_load, (state_r == ST_FIN) && out_free, out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Interval overlap accounting testbench
// Drives add, observe, direct and unused-code transactions through the
// valid/ready input channel and checks every result against a cycle-free
// model of the interval tables and the saturating totals. Covers boundary
// intervals, table-full rejection, random interval bursts closed by an
// observe window, output back-pressure and saturation of all totals.
// ----------------------------------------------------------------------------
module tb_top
  import ioa_pkg::*;
();

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic       DEVICE_TO_HOST = ~HOST_TO_DEVICE;
  localparam logic [63:0] TIME_MAX      = '1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  interval_overlap_accounting dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // model of the tables and totals
  logic [63:0] conc_lo [CONC_DEPTH_DEF];
  logic [63:0] conc_hi [CONC_DEPTH_DEF];
  int          conc_count = 0;
  logic [63:0] xfer_lo [XFER_DEPTH_DEF];
  logic [63:0] xfer_hi [XFER_DEPTH_DEF];
  logic        xfer_way [XFER_DEPTH_DEF];
  int          xfer_count = 0;
  logic [63:0] stall_acc   = '0;
  logic [63:0] overlap_acc = '0;
  logic [63:0] h2d_acc     = '0;
  logic [63:0] d2h_acc     = '0;

  out_item_t expected_totals[$];
  int        error_count = 0;
  int        items_sent  = 0;
  bit        idle_on     = 1'b0;
  int        sink_hold   = 0;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? TIME_MAX : s[63:0];
  endfunction

  function automatic logic [63:0] span_of(input logic [63:0] s, input logic [63:0] e);
    return (e > s) ? e - s : 64'd0;
  endfunction

  function automatic logic [63:0] overlap_of(input logic [63:0] s, input logic [63:0] e,
                                             input logic [63:0] ws, input logic [63:0] we);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = (s > ws) ? s : ws;
    hi = (e < we) ? e : we;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  function automatic out_item_t account_item(input in_item_t it);
    out_item_t   res;
    logic [63:0] ov;
    logic        c_full;
    logic        x_full;
    res = '0;
    res.accepted = 1'b1;
    case (it.operation)
      OP_ADD: begin
        if (span_of(it.start_ns, it.end_ns) != 0) begin
          c_full = conc_count >= CONC_DEPTH_DEF;
          x_full = xfer_count >= XFER_DEPTH_DEF;
          if ((it.to_concurrent && c_full) || (it.to_transfer && x_full)) begin
            res.accepted = 1'b0;
          end else begin
            if (it.to_concurrent) begin
              conc_lo[conc_count] = it.start_ns;
              conc_hi[conc_count] = it.end_ns;
              conc_count++;
            end
            if (it.to_transfer) begin
              xfer_lo[xfer_count]  = it.start_ns;
              xfer_hi[xfer_count]  = it.end_ns;
              xfer_way[xfer_count] = it.direction;
              xfer_count++;
            end
          end
        end
      end
      OP_OBSERVE: begin
        for (int i = 0; i < conc_count; i++) begin
          ov = overlap_of(conc_lo[i], conc_hi[i], it.start_ns, it.end_ns);
          stall_acc = sat_add64(stall_acc, span_of(conc_lo[i], conc_hi[i]) - ov);
        end
        for (int i = 0; i < xfer_count; i++) begin
          ov = overlap_of(xfer_lo[i], xfer_hi[i], it.start_ns, it.end_ns);
          overlap_acc = sat_add64(overlap_acc, ov);
          if (xfer_way[i] == HOST_TO_DEVICE) begin
            h2d_acc = sat_add64(h2d_acc, ov);
          end else begin
            d2h_acc = sat_add64(d2h_acc, ov);
          end
        end
        conc_count = 0;
        xfer_count = 0;
      end
      OP_DIRECT: begin
        stall_acc = sat_add64(stall_acc, span_of(it.start_ns, it.end_ns));
      end
      default: begin
      end
    endcase
    res.stall_sum   = stall_acc;
    res.overlap_sum = overlap_acc;
    res.h2d_sum     = h2d_acc;
    res.d2h_sum     = d2h_acc;
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] op, input logic [63:0] s,
                                         input logic [63:0] e, input logic tc,
                                         input logic tx, input logic dir);
    in_item_t it;
    it.operation     = op;
    it.start_ns      = s;
    it.end_ns        = e;
    it.to_concurrent = tc;
    it.to_transfer   = tx;
    it.direction     = dir;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%016h, actual 0x%016h", name, want, got);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_totals.size() == 0) begin
        $error("result transaction with no expected result pending");
        error_count++;
      end else begin
        want = expected_totals.pop_front();
        check_field("accepted", 64'(want.accepted), 64'(out_data.accepted));
        check_field("stall_sum", want.stall_sum, out_data.stall_sum);
        check_field("overlap_sum", want.overlap_sum, out_data.overlap_sum);
        check_field("h2d_sum", want.h2d_sum, out_data.h2d_sum);
        check_field("d2h_sum", want.d2h_sum, out_data.d2h_sum);
      end
    end
  end

  // result receiver: long hold-off, random bursts, otherwise ready
  initial begin : sink_ready
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        sink_hold--;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 7) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input in_item_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_totals.push_back(account_item(item));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(negedge clk);
  endtask

  task automatic test_single_ops();
    send_item(make_item(OP_ADD, TIME_MAX, 64'd0, 1'b1, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_ADD, TIME_MAX, TIME_MAX, 1'b1, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd10, 64'd20, 1'b0, 1'b0, DEVICE_TO_HOST));
    send_item(make_item(OP_UNUSED, TIME_MAX, TIME_MAX, 1'b1, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_DIRECT, 64'd5, 64'd5, 1'b0, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_DIRECT, 64'd0, 64'd100, 1'b1, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_DIRECT, TIME_MAX, 64'd0, 1'b0, 1'b1, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd100, 64'd200, 1'b1, 1'b0, DEVICE_TO_HOST));
    send_item(make_item(OP_ADD, 64'd150, 64'd300, 1'b0, 1'b1, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, TIME_MAX - 10, TIME_MAX, 1'b1, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_ADD, 64'd0, 64'd1, 1'b1, 1'b1, HOST_TO_DEVICE));
    send_item(make_item(OP_OBSERVE, 64'd120, 64'd250, 1'b1, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_OBSERVE, 64'd0, TIME_MAX, 1'b0, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd1000, 64'd2000, 1'b1, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd1500, 64'd2500, 1'b0, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_OBSERVE, 64'd3000, 64'd0, 1'b0, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, TIME_MAX - 5, TIME_MAX, 1'b1, 1'b1, HOST_TO_DEVICE));
    send_item(make_item(OP_OBSERVE, TIME_MAX - 3, TIME_MAX, 1'b1, 1'b0, DEVICE_TO_HOST));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < CONC_DEPTH_DEF; i++) begin
      send_item(make_item(OP_ADD, 64'(i * 10), 64'(i * 10 + 5), 1'b1, 1'b0, rand_bit()));
    end
    send_item(make_item(OP_ADD, 64'd400, 64'd500, 1'b1, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd400, 64'd500, 1'b1, 1'b1, DEVICE_TO_HOST));
    for (int i = 0; i < XFER_DEPTH_DEF; i++) begin
      send_item(make_item(OP_ADD, 64'(i * 20), 64'(i * 20 + 15), 1'b0, 1'b1, rand_bit()));
    end
    send_item(make_item(OP_ADD, 64'd600, 64'd700, 1'b0, 1'b1, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd700, 64'd700, 1'b1, 1'b1, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd700, 64'd800, 1'b0, 1'b0, DEVICE_TO_HOST));
    send_item(make_item(OP_OBSERVE, 64'd50, 64'd250, 1'b0, 1'b0, HOST_TO_DEVICE));
  endtask

  // burst of adds near one time base, closed by an observe window
  task automatic send_sequence(input bit wide_base);
    logic [63:0] base;
    logic [63:0] s;
    logic [63:0] e;
    int          n;
    base = wide_base ? rand64() : 64'($urandom_range(0, 1 << 20));
    n = $urandom_range(0, 20);
    repeat (n) begin
      s = base + 64'($urandom_range(0, 4000));
      e = ($urandom_range(0, 15) == 0) ? s - 64'($urandom_range(0, 100))
                                        : s + 64'($urandom_range(1, 3000));
      send_item(make_item(OP_ADD, s, e, rand_bit(), rand_bit(), rand_bit()));
    end
    if ($urandom_range(0, 7) == 0) begin
      s = rand64();
      e = rand64();
    end else begin
      s = base + 64'($urandom_range(0, 4000));
      e = s + 64'($urandom_range(0, 5000));
    end
    send_item(make_item(OP_OBSERVE, s, e, rand_bit(), rand_bit(), rand_bit()));
  endtask

  task automatic send_noise();
    logic [63:0] s;
    s = rand64();
    case ($urandom_range(0, 3))
      0: send_item(make_item(OP_UNUSED, s, rand64(), rand_bit(), rand_bit(), rand_bit()));
      1: send_item(make_item(OP_ADD, s, s - 64'($urandom_range(0, 1000)),
                             rand_bit(), rand_bit(), rand_bit()));
      2: send_item(make_item(OP_DIRECT, s, s + 64'($urandom_range(0, 3000)),
                             rand_bit(), rand_bit(), rand_bit()));
      default: send_item(make_item(OP_OBSERVE, s, rand64(),
                                   rand_bit(), rand_bit(), rand_bit()));
    endcase
  endtask

  task automatic test_random_traffic(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_sequence($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 49) == 0) begin
        wait_drained();
      end
    end
  endtask

  task automatic test_output_stall();
    sink_hold = 300;
    repeat (3) send_sequence(1'b0);
    wait_drained();
    repeat (2) send_sequence(1'b0);
  endtask

  task automatic test_saturation();
    send_item(make_item(OP_DIRECT, 64'd0, TIME_MAX, 1'b0, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_DIRECT, 64'd0, 64'd10, 1'b0, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd0, TIME_MAX, 1'b1, 1'b1, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd1, TIME_MAX, 1'b0, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_OBSERVE, 64'd0, TIME_MAX, 1'b0, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_ADD, 64'd0, TIME_MAX, 1'b1, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_ADD, 64'd0, TIME_MAX, 1'b0, 1'b1, HOST_TO_DEVICE));
    send_item(make_item(OP_OBSERVE, 64'd0, 64'd1, 1'b1, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_ADD, 64'd0, TIME_MAX, 1'b0, 1'b1, DEVICE_TO_HOST));
    send_item(make_item(OP_OBSERVE, 64'd0, TIME_MAX, 1'b0, 1'b0, HOST_TO_DEVICE));
    send_item(make_item(OP_DIRECT, 64'd0, 64'd1, 1'b0, 1'b0, HOST_TO_DEVICE));
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n   <= 1'b1;
    idle_on = 1'b1;
    test_single_ops();
    test_table_full();
    test_random_traffic(1400);
    test_output_stall();
    idle_on = 1'b0;
    test_random_traffic(250);
    test_saturation();
    wait_drained();
    repeat (60) @(negedge clk);
    if (error_count == 0 && expected_totals.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
